@@ design/pblt_pkg.sv @@
// ----------------------------------------------------------------------------
// Packet buffer lifecycle table: shared definitions
// Command, state and status codes, the descriptor record and the control
// structures passed between the table's modules.
// ----------------------------------------------------------------------------
`default_nettype none

package pblt_pkg;

    localparam int SLOTS  = 32;
    localparam int SLOT_W = 5;
    localparam int CNT_W  = 6;

    localparam logic [12:0] MAX_ALIGN = 13'd4096;
    localparam logic [15:0] REF_MAX   = 16'hFFFF;

    typedef enum logic [2:0] {
        CMD_ALLOCATE   = 3'd0,
        CMD_SET_LAYOUT = 3'd1,
        CMD_SET_LENGTH = 3'd2,
        CMD_TRANSITION = 3'd3,
        CMD_COMPLETE   = 3'd4,
        CMD_RETAIN     = 3'd5,
        CMD_RELEASE    = 3'd6
    } cmd_t;

    typedef enum logic [2:0] {
        S_INVALID   = 3'd0,
        S_ALLOCATED = 3'd1,
        S_RX        = 3'd2,
        S_QUEUED    = 3'd3,
        S_IN_FLIGHT = 3'd4,
        S_DELIVERED = 3'd5,
        S_DROPPED   = 3'd6,
        S_FREED     = 3'd7
    } desc_state_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_INVALID  = 2'd1,
        ST_STATE    = 2'd2,
        ST_OVERFLOW = 2'd3
    } status_t;

    localparam logic [2:0] O_NONE     = 3'd0;
    localparam logic [2:0] O_DRIVER   = 3'd1;
    localparam logic [2:0] O_ETHERNET = 3'd2;
    localparam logic [2:0] O_PROTOCOL = 3'd3;
    localparam logic [2:0] O_SOCKET   = 3'd4;

    // One descriptor as stored in the table memory.
    typedef struct packed {
        desc_state_t state;
        logic [2:0]  owner;
        logic [15:0] refs;
        logic [15:0] capacity;
        logic [15:0] headroom;
        logic [15:0] length;
        logic [15:0] tailroom;
        logic [7:0]  error;
    } desc_t;

    // One command beat as held in the execute stage.
    typedef struct packed {
        cmd_t        cmd;
        logic [SLOT_W-1:0] slot;
        logic [15:0] capacity;
        logic [15:0] headroom;
        logic [15:0] payload_length;
        logic [12:0] alignment;
        desc_state_t next_state;
        logic [2:0]  next_owner;
        logic [7:0]  completion_code;
    } cmd_item_t;

    // Decision of the command unit for one command.
    typedef struct packed {
        status_t status;
        logic    count_fail;
        logic    count_dup;
        logic    wr_en;
        desc_t   wr_entry;
        logic    busy_set;
        logic    busy_clr;
        logic    show;
    } dec_t;

endpackage

`default_nettype wire

@@ design/pblt_desc_mem.sv @@
// ----------------------------------------------------------------------------
// Descriptor memory
// One write port and one read port with a registered read. Contents are
// undefined until written.
// ----------------------------------------------------------------------------
`default_nettype none

module pblt_desc_mem (
    input  wire logic                         clk,
    input  wire logic                         rd_en,
    input  wire logic [pblt_pkg::SLOT_W-1:0]  rd_addr,
    output pblt_pkg::desc_t                   rd_data,
    input  wire logic                         wr_en,
    input  wire logic [pblt_pkg::SLOT_W-1:0]  wr_addr,
    input  pblt_pkg::desc_t                   wr_data
);
    import pblt_pkg::*;

    desc_t mem [SLOTS];
    desc_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

@@ design/pblt_cmd_unit.sv @@
// ----------------------------------------------------------------------------
// Command unit
// Checks one command against the addressed descriptor and decides the
// status, the descriptor write-back and the changes to the slot map.
// ----------------------------------------------------------------------------
`default_nettype none

module pblt_cmd_unit (
    input  pblt_pkg::cmd_item_t item,
    input  pblt_pkg::desc_t     cur,
    input  wire logic           busy,
    input  wire logic           free_found,
    output pblt_pkg::dec_t      dec
);
    import pblt_pkg::*;

    function automatic logic owner_ok(input logic [2:0] o);
        return (o >= O_DRIVER) && (o <= O_SOCKET);
    endfunction

    function automatic logic pair_ok(input desc_state_t s, input logic [2:0] o);
        logic ok;
        case (s) inside
            S_ALLOCATED, S_IN_FLIGHT: ok = owner_ok(o);
            S_RX:                     ok = (o == O_DRIVER) || (o == O_ETHERNET);
            S_QUEUED:                 ok = (o == O_PROTOCOL) || (o == O_SOCKET);
            S_DROPPED:                ok = (o == O_NONE);
            S_DELIVERED:              ok = (o == O_NONE) || owner_ok(o);
            default:                  ok = 1'b0;
        endcase
        return ok;
    endfunction

    function automatic logic move_ok(input desc_state_t c, input desc_state_t n);
        logic ok;
        case (c)
            S_ALLOCATED: ok = (n == S_RX) || (n == S_QUEUED) || (n == S_IN_FLIGHT);
            S_RX:        ok = (n == S_QUEUED) || (n == S_IN_FLIGHT);
            S_QUEUED:    ok = (n == S_IN_FLIGHT);
            default:     ok = 1'b0;
        endcase
        return ok;
    endfunction

    status_t     live;
    logic        finished;
    logic        quiet;
    logic [15:0] lay_head;
    logic [15:0] room;
    logic        alloc_bad;

    always_comb
    begin
        if (!busy)
        begin
            live = ST_INVALID;
        end
        else if ((cur.refs == 16'd0) || (cur.state == S_FREED))
        begin
            live = ST_STATE;
        end
        else
        begin
            live = ST_OK;
        end
        finished  = (cur.state == S_DELIVERED) || (cur.state == S_DROPPED);
        lay_head  = (item.cmd == CMD_SET_LENGTH) ? cur.headroom : item.headroom;
        room      = cur.capacity - lay_head;
        alloc_bad = (item.capacity == 16'd0) || (item.headroom > item.capacity) ||
                    !$onehot(item.alignment) || (item.alignment > MAX_ALIGN) ||
                    !owner_ok(item.next_owner);
    end

    always_comb
    begin
        dec          = '0;
        dec.status   = ST_OK;
        dec.show     = 1'b1;
        dec.wr_entry = cur;
        quiet        = 1'b0;

        case (item.cmd)
            CMD_ALLOCATE:
            begin
                dec.show = 1'b0;
                if (alloc_bad)
                begin
                    dec.status = ST_INVALID;
                    quiet      = 1'b1;
                end
                else if (!free_found)
                begin
                    dec.status = ST_OVERFLOW;
                end
                else
                begin
                    dec.show              = 1'b1;
                    dec.wr_en             = 1'b1;
                    dec.busy_set          = 1'b1;
                    dec.wr_entry.state    = S_ALLOCATED;
                    dec.wr_entry.owner    = item.next_owner;
                    dec.wr_entry.refs     = 16'd1;
                    dec.wr_entry.capacity = item.capacity;
                    dec.wr_entry.headroom = item.headroom;
                    dec.wr_entry.length   = 16'd0;
                    dec.wr_entry.tailroom = item.capacity - item.headroom;
                    dec.wr_entry.error    = 8'd0;
                end
            end
            CMD_SET_LAYOUT, CMD_SET_LENGTH:
            begin
                if (live != ST_OK)
                begin
                    dec.status = live;
                end
                else if (finished)
                begin
                    dec.status = ST_STATE;
                end
                else if ((lay_head > cur.capacity) || (item.payload_length > room))
                begin
                    dec.status = ST_OVERFLOW;
                end
                else
                begin
                    dec.wr_en             = 1'b1;
                    dec.wr_entry.headroom = lay_head;
                    dec.wr_entry.length   = item.payload_length;
                    dec.wr_entry.tailroom = room - item.payload_length;
                end
            end
            CMD_TRANSITION:
            begin
                if (!owner_ok(item.next_owner) || (item.next_state == S_INVALID) ||
                    (item.next_state == S_FREED) || (item.next_state == S_DELIVERED) ||
                    (item.next_state == S_DROPPED))
                begin
                    dec.status = ST_INVALID;
                end
                else if (live != ST_OK)
                begin
                    dec.status = live;
                end
                else if (!move_ok(cur.state, item.next_state))
                begin
                    dec.status = ST_STATE;
                end
                else if (!pair_ok(item.next_state, item.next_owner))
                begin
                    dec.status = ST_INVALID;
                end
                else
                begin
                    dec.wr_en          = 1'b1;
                    dec.wr_entry.state = item.next_state;
                    dec.wr_entry.owner = item.next_owner;
                end
            end
            CMD_COMPLETE:
            begin
                if (live != ST_OK)
                begin
                    dec.status = live;
                end
                else if (finished)
                begin
                    dec.status    = ST_STATE;
                    dec.count_dup = 1'b1;
                end
                else if (item.completion_code == 8'd0)
                begin
                    if ((cur.state != S_RX) && (cur.state != S_IN_FLIGHT))
                    begin
                        dec.status = ST_STATE;
                    end
                    else if (item.next_owner > O_SOCKET)
                    begin
                        dec.status = ST_INVALID;
                    end
                    else
                    begin
                        dec.wr_en          = 1'b1;
                        dec.wr_entry.state = S_DELIVERED;
                        dec.wr_entry.owner = item.next_owner;
                    end
                end
                else
                begin
                    if ((cur.state < S_ALLOCATED) || (cur.state > S_IN_FLIGHT))
                    begin
                        dec.status = ST_STATE;
                    end
                    else if (item.next_owner != O_NONE)
                    begin
                        dec.status = ST_INVALID;
                    end
                    else
                    begin
                        dec.wr_en          = 1'b1;
                        dec.wr_entry.state = S_DROPPED;
                        dec.wr_entry.owner = O_NONE;
                        dec.wr_entry.error = item.completion_code;
                    end
                end
            end
            CMD_RETAIN:
            begin
                if (live != ST_OK)
                begin
                    dec.status = live;
                end
                else if (cur.refs == REF_MAX)
                begin
                    dec.status = ST_OVERFLOW;
                end
                else
                begin
                    dec.wr_en         = 1'b1;
                    dec.wr_entry.refs = cur.refs + 16'd1;
                end
            end
            CMD_RELEASE:
            begin
                if (live != ST_OK)
                begin
                    dec.status = live;
                end
                else if (!finished)
                begin
                    dec.status = ST_STATE;
                end
                else if (cur.refs > 16'd1)
                begin
                    dec.wr_en         = 1'b1;
                    dec.wr_entry.refs = cur.refs - 16'd1;
                end
                else
                begin
                    dec.wr_en          = 1'b1;
                    dec.busy_clr       = 1'b1;
                    dec.wr_entry.refs  = 16'd0;
                    dec.wr_entry.state = S_FREED;
                    dec.wr_entry.owner = O_NONE;
                end
            end
            default:
            begin
                dec.status = ST_INVALID;
                quiet      = 1'b1;
            end
        endcase

        dec.count_fail = (dec.status != ST_OK) && !quiet;
    end

endmodule

`default_nettype wire

@@ design/packet_buffer_lifecycle_table.sv @@
// ----------------------------------------------------------------------------
// Packet buffer lifecycle table
// Descriptor table for packet buffers with allocate, layout, state, completion
// and reference commands, plus running buffer and failure counts.
// ----------------------------------------------------------------------------
// Usage:
// Commands arrive on the input channel (in_valid / in_stall), one command per
// beat; every command produces exactly one result beat on the output channel
// (out_valid / out_stall). The result carries the status, the granted slot of
// an allocate, the addressed descriptor after the command and the running
// counters after the command.
// The edge that accepts a command starts the descriptor memory read, and
// the edge on which the execute stage finishes writes the descriptor back
// and loads the result register. A new command is taken every cycle while
// in_stall is low, so the sustained rate is one command per cycle; it is set
// by the single read-modify-write of the descriptor memory, with the write-back
// of one command forwarded to the read of the next when both hit the same slot.
// After reset every slot is free, all descriptors read as invalid with no
// owner and no references (per-slot valid bits, no clearing pass), and all
// counters are zero. When the receiver stalls, the result beat holds; one more
// command may then sit in the execute stage, after which in_stall rises.
// ----------------------------------------------------------------------------
`default_nettype none

module packet_buffer_lifecycle_table (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [2:0]  cmd,
    input  wire logic [4:0]  slot,
    input  wire logic [15:0] capacity,
    input  wire logic [15:0] headroom,
    input  wire logic [15:0] payload_length,
    input  wire logic [12:0] alignment,
    input  wire logic [2:0]  next_state,
    input  wire logic [2:0]  next_owner,
    input  wire logic [7:0]  completion_code,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [1:0]       status,
    output logic [4:0]       granted_slot,
    output logic [2:0]       entry_state,
    output logic [2:0]       entry_owner,
    output logic [15:0]      entry_refs,
    output logic [15:0]      entry_tailroom,
    output logic [5:0]       active_count,
    output logic [5:0]       peak_count,
    output logic [31:0]      failure_count,
    output logic [31:0]      duplicate_count,
    output logic [1:0]       last_error_code
);
    import pblt_pkg::*;

    // Execute stage.
    logic              s1_valid_reg;
    cmd_item_t         s1_item_reg;
    logic              fwd_hit_reg;
    desc_t             fwd_entry_reg;
    cmd_item_t         in_item;
    logic              accept;
    logic              s1_done;

    // Slot map and counters.
    logic [SLOTS-1:0]  busy_reg;
    logic [SLOTS-1:0]  valid_reg;
    logic [CNT_W-1:0]  active_reg;
    logic [CNT_W-1:0]  active_next;
    logic [CNT_W-1:0]  peak_reg;
    logic [CNT_W-1:0]  peak_next;
    logic [31:0]       fail_reg;
    logic [31:0]       dup_reg;
    status_t           last_err_reg;

    // Result register.
    logic              out_valid_reg;
    status_t           status_reg;
    logic [SLOT_W-1:0] granted_reg;
    desc_state_t       ent_state_reg;
    logic [2:0]        ent_owner_reg;
    logic [15:0]       ent_refs_reg;
    logic [15:0]       ent_tail_reg;

    // Execute-stage datapath.
    desc_t             rd_entry;
    desc_t             cur_entry;
    desc_t             shown;
    dec_t              dec;
    logic              free_found;
    logic [SLOT_W-1:0] free_idx;
    logic              is_alloc;
    logic [SLOT_W-1:0] wr_addr;
    logic              mem_wr_en;
    logic              busy_after;

    assign in_item = '{
        cmd:             cmd_t'(cmd),
        slot:            slot,
        capacity:        capacity,
        headroom:        headroom,
        payload_length:  payload_length,
        alignment:       alignment,
        next_state:      desc_state_t'(next_state),
        next_owner:      next_owner,
        completion_code: completion_code
    };

    // The execute stage finishes whenever the result register is free or is
    // being emptied in this cycle.
    assign s1_done  = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !s1_done;
    assign accept   = in_valid && !in_stall;

    // Lowest free slot for allocate.
    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (!busy_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = SLOT_W'(i);
            end
        end
    end

    pblt_desc_mem u_mem (
        .clk     (clk),
        .rd_en   (accept),
        .rd_addr (slot),
        .rd_data (rd_entry),
        .wr_en   (mem_wr_en),
        .wr_addr (wr_addr),
        .wr_data (dec.wr_entry)
    );

    // A write-back in the same cycle as the read is forwarded. A slot that was
    // never written reads as invalid with no owner and no references.
    always_comb
    begin
        cur_entry = fwd_hit_reg ? fwd_entry_reg : rd_entry;
        if (!valid_reg[s1_item_reg.slot])
        begin
            cur_entry.state = S_INVALID;
            cur_entry.owner = O_NONE;
            cur_entry.refs  = 16'd0;
        end
    end

    pblt_cmd_unit u_cmd (
        .item       (s1_item_reg),
        .cur        (cur_entry),
        .busy       (busy_reg[s1_item_reg.slot]),
        .free_found (free_found),
        .dec        (dec)
    );

    assign is_alloc  = (s1_item_reg.cmd == CMD_ALLOCATE);
    assign wr_addr   = is_alloc ? free_idx : s1_item_reg.slot;
    assign mem_wr_en = s1_done && dec.wr_en;

    always_comb
    begin
        shown      = dec.wr_en ? dec.wr_entry : cur_entry;
        busy_after = dec.busy_set || (busy_reg[s1_item_reg.slot] && !dec.busy_clr);

        active_next = active_reg;
        if (dec.busy_set)
        begin
            active_next = active_reg + CNT_W'(1);
        end
        else if (dec.busy_clr && (active_reg != '0))
        begin
            active_next = active_reg - CNT_W'(1);
        end
        peak_next = (active_next > peak_reg) ? active_next : peak_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            fwd_hit_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            busy_reg      <= '0;
            valid_reg     <= '0;
            active_reg    <= '0;
            peak_reg      <= '0;
            fail_reg      <= '0;
            dup_reg       <= '0;
            last_err_reg  <= ST_OK;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
                fwd_hit_reg  <= mem_wr_en && (wr_addr == slot);
            end
            else if (s1_done)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_done)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            if (s1_done)
            begin
                if (dec.wr_en)
                begin
                    valid_reg[wr_addr] <= 1'b1;
                end
                if (dec.busy_set)
                begin
                    busy_reg[wr_addr] <= 1'b1;
                end
                else if (dec.busy_clr)
                begin
                    busy_reg[wr_addr] <= 1'b0;
                end
                active_reg <= active_next;
                peak_reg   <= peak_next;
                if (dec.count_fail)
                begin
                    fail_reg     <= fail_reg + 32'd1;
                    last_err_reg <= dec.status;
                end
                if (dec.count_dup)
                begin
                    dup_reg <= dup_reg + 32'd1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_item_reg   <= in_item;
            fwd_entry_reg <= dec.wr_entry;
        end
        if (s1_done)
        begin
            status_reg  <= dec.status;
            granted_reg <= (is_alloc && dec.wr_en) ? free_idx : '0;
            if (dec.show)
            begin
                ent_state_reg <= shown.state;
                ent_owner_reg <= shown.owner;
                ent_refs_reg  <= shown.refs;
                ent_tail_reg  <= busy_after ? shown.tailroom : 16'd0;
            end
            else
            begin
                ent_state_reg <= S_INVALID;
                ent_owner_reg <= O_NONE;
                ent_refs_reg  <= 16'd0;
                ent_tail_reg  <= 16'd0;
            end
        end
    end

    assign out_valid       = out_valid_reg;
    assign status          = status_reg;
    assign granted_slot    = granted_reg;
    assign entry_state     = ent_state_reg;
    assign entry_owner     = ent_owner_reg;
    assign entry_refs      = ent_refs_reg;
    assign entry_tailroom  = ent_tail_reg;
    assign active_count    = active_reg;
    assign peak_count      = peak_reg;
    assign failure_count   = fail_reg;
    assign duplicate_count = dup_reg;
    assign last_error_code = last_err_reg;

    // The active count always matches the number of busy slots.
    a_active_matches_map : assert property (@(posedge clk) disable iff (!rst_n)
        active_reg == CNT_W'($countones(busy_reg)))
        else $error("active count differs from busy slot map");

    // The peak never falls below the current count.
    a_peak_bound : assert property (@(posedge clk) disable iff (!rst_n)
        peak_reg >= active_reg)
        else $error("peak count below active count");

    // A busy slot has always been written.
    a_busy_written : assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg & ~valid_reg) == '0)
        else $error("busy slot was never written");

    // A duplicate completion is always also a failure.
    a_dup_is_fail : assert property (@(posedge clk) disable iff (!rst_n)
        (dup_reg != $past(dup_reg)) |-> (fail_reg != $past(fail_reg)))
        else $error("duplicate counted without failure");

    // A stalled execute stage must not write the table.
    a_no_write_in_stall : assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && out_valid_reg && out_stall) |-> !mem_wr_en)
        else $error("descriptor written while result is stalled");

endmodule

`default_nettype wire

@@ tb/packet_buffer_lifecycle_table_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Packet buffer lifecycle table: result checker
// Watches the command and result channels and keeps its own copy of the
// descriptor table and counters. Each accepted command queues its predicted
// result; each accepted result beat is compared field by field with the oldest
// prediction.
// ----------------------------------------------------------------------------
module packet_buffer_lifecycle_table_checker
    import pblt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [2:0]  cmd,
    input  logic [4:0]  slot,
    input  logic [15:0] capacity,
    input  logic [15:0] headroom,
    input  logic [15:0] payload_length,
    input  logic [12:0] alignment,
    input  logic [2:0]  next_state,
    input  logic [2:0]  next_owner,
    input  logic [7:0]  completion_code,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [1:0]  status,
    input  logic [4:0]  granted_slot,
    input  logic [2:0]  entry_state,
    input  logic [2:0]  entry_owner,
    input  logic [15:0] entry_refs,
    input  logic [15:0] entry_tailroom,
    input  logic [5:0]  active_count,
    input  logic [5:0]  peak_count,
    input  logic [31:0] failure_count,
    input  logic [31:0] duplicate_count,
    input  logic [1:0]  last_error_code,
    output int unsigned mismatches,
    output int unsigned backlog
);

    typedef struct packed {
        logic [2:0]  op;
        logic [4:0]  slot;
        logic [15:0] capacity;
        logic [15:0] headroom;
        logic [15:0] payload_length;
        logic [12:0] alignment;
        logic [2:0]  next_state;
        logic [2:0]  next_owner;
        logic [7:0]  completion_code;
    } table_cmd_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [4:0]  granted;
        logic [2:0]  state;
        logic [2:0]  owner;
        logic [15:0] refs;
        logic [15:0] tailroom;
        logic [5:0]  active;
        logic [5:0]  peak;
        logic [31:0] fails;
        logic [31:0] dups;
        logic [1:0]  last_err;
    } table_result_t;

    // Shadow copy of the descriptor table and its counters.
    logic        slot_busy  [SLOTS];
    desc_state_t slot_state [SLOTS];
    logic [2:0]  slot_owner [SLOTS];
    logic [15:0] slot_refs  [SLOTS];
    logic [15:0] slot_cap   [SLOTS];
    logic [15:0] slot_head  [SLOTS];
    logic [15:0] slot_len   [SLOTS];
    logic [15:0] slot_tail  [SLOTS];
    logic [7:0]  slot_err   [SLOTS];
    logic [5:0]  live_count;
    logic [5:0]  peak_seen;
    logic [31:0] fails_seen;
    logic [31:0] dups_seen;
    status_t     last_fault;

    table_result_t pending_results [$];

    initial begin
        mismatches = 0;
        backlog    = 0;
    end

    function automatic void clear_table();
        for (int k = 0; k < SLOTS; k++) begin
            slot_busy[k]  = 1'b0;
            slot_state[k] = S_INVALID;
            slot_owner[k] = O_NONE;
            slot_refs[k]  = '0;
            slot_cap[k]   = '0;
            slot_head[k]  = '0;
            slot_len[k]   = '0;
            slot_tail[k]  = '0;
            slot_err[k]   = '0;
        end
        live_count = '0;
        peak_seen  = '0;
        fails_seen = '0;
        dups_seen  = '0;
        last_fault = ST_OK;
    endfunction

    function automatic bit owner_valid(logic [2:0] o);
        return o >= O_DRIVER && o <= O_SOCKET;
    endfunction

    function automatic bit pair_valid(desc_state_t s, logic [2:0] o);
        case (s)
            S_ALLOCATED, S_IN_FLIGHT: return owner_valid(o);
            S_RX:                     return o == O_DRIVER || o == O_ETHERNET;
            S_QUEUED:                 return o == O_PROTOCOL || o == O_SOCKET;
            S_DROPPED:                return o == O_NONE;
            S_DELIVERED:              return o == O_NONE || owner_valid(o);
            default:                  return 1'b0;
        endcase
    endfunction

    function automatic bit move_valid(desc_state_t cur, desc_state_t nxt);
        case (cur)
            S_ALLOCATED: return nxt == S_RX || nxt == S_QUEUED || nxt == S_IN_FLIGHT;
            S_RX:        return nxt == S_QUEUED || nxt == S_IN_FLIGHT;
            S_QUEUED:    return nxt == S_IN_FLIGHT;
            default:     return 1'b0;
        endcase
    endfunction

    function automatic bit align_valid(logic [12:0] a);
        if (a == '0 || a > MAX_ALIGN)
            return 1'b0;
        return (a & (a - 13'd1)) == '0;
    endfunction

    function automatic status_t note_failure(status_t code, bit dup);
        fails_seen = fails_seen + 32'd1;
        if (dup)
            dups_seen = dups_seen + 32'd1;
        last_fault = code;
        return code;
    endfunction

    function automatic status_t liveness(int unsigned s);
        if (!slot_busy[s])
            return ST_INVALID;
        if (slot_refs[s] == '0 || slot_state[s] == S_FREED)
            return ST_STATE;
        return ST_OK;
    endfunction

    // Headroom and length update on a live descriptor; counts its own failure.
    function automatic status_t fit_layout(int unsigned s, int unsigned head,
                                           int unsigned len);
        int unsigned cap;
        status_t     r;
        cap = slot_cap[s];
        r   = ST_OK;
        if (slot_state[s] == S_DELIVERED || slot_state[s] == S_DROPPED)
            r = ST_STATE;
        else if (head > cap)
            r = ST_OVERFLOW;
        else if (len > cap - head)
            r = ST_OVERFLOW;
        if (r != ST_OK)
            return note_failure(r, 1'b0);
        slot_head[s] = 16'(head);
        slot_len[s]  = 16'(len);
        slot_tail[s] = 16'(cap - head - len);
        return ST_OK;
    endfunction

    function automatic table_result_t run_command(table_cmd_t c);
        table_result_t r;
        status_t       st;
        int unsigned   s;
        int unsigned   i;
        int unsigned   cap;
        int unsigned   head;
        logic [4:0]    granted;
        bit            show;
        desc_state_t   target;
        st      = ST_OK;
        granted = '0;
        show    = 1'b1;
        s       = c.slot;
        cap     = c.capacity;
        head    = c.headroom;
        target  = desc_state_t'(c.next_state);
        case (c.op)
            CMD_ALLOCATE:
            begin
                show = 1'b0;
                if (cap == 0 || head > cap || !align_valid(c.alignment) ||
                    !owner_valid(c.next_owner))
                begin
                    st = ST_INVALID;
                end
                else
                begin
                    i = 0;
                    while (i < SLOTS && slot_busy[i])
                        i++;
                    if (i >= SLOTS)
                        st = note_failure(ST_OVERFLOW, 1'b0);
                    else
                    begin
                        slot_busy[i]  = 1'b1;
                        slot_state[i] = S_ALLOCATED;
                        slot_owner[i] = c.next_owner;
                        slot_refs[i]  = 16'd1;
                        slot_cap[i]   = c.capacity;
                        slot_head[i]  = c.headroom;
                        slot_len[i]   = '0;
                        slot_tail[i]  = 16'(cap - head);
                        slot_err[i]   = '0;
                        live_count    = live_count + 6'd1;
                        if (live_count > peak_seen)
                            peak_seen = live_count;
                        granted = 5'(i);
                        s       = i;
                        show    = 1'b1;
                    end
                end
            end
            CMD_SET_LAYOUT:
            begin
                st = liveness(s);
                if (st != ST_OK)
                    void'(note_failure(st, 1'b0));
                else
                    st = fit_layout(s, head, c.payload_length);
            end
            CMD_SET_LENGTH:
            begin
                st = liveness(s);
                if (st != ST_OK)
                    void'(note_failure(st, 1'b0));
                else
                    st = fit_layout(s, slot_head[s], c.payload_length);
            end
            CMD_TRANSITION:
            begin
                if (!owner_valid(c.next_owner) || target == S_INVALID ||
                    target == S_FREED || target == S_DELIVERED || target == S_DROPPED)
                begin
                    st = note_failure(ST_INVALID, 1'b0);
                end
                else
                begin
                    st = liveness(s);
                    if (st == ST_OK && !move_valid(slot_state[s], target))
                        st = ST_STATE;
                    if (st == ST_OK && !pair_valid(target, c.next_owner))
                        st = ST_INVALID;
                    if (st != ST_OK)
                        void'(note_failure(st, 1'b0));
                    else
                    begin
                        slot_state[s] = target;
                        slot_owner[s] = c.next_owner;
                    end
                end
            end
            CMD_COMPLETE:
            begin
                st = liveness(s);
                if (st != ST_OK)
                    void'(note_failure(st, 1'b0));
                else if (slot_state[s] == S_DELIVERED || slot_state[s] == S_DROPPED)
                    st = note_failure(ST_STATE, 1'b1);
                else if (c.completion_code == '0)
                begin
                    if (slot_state[s] != S_RX && slot_state[s] != S_IN_FLIGHT)
                        st = note_failure(ST_STATE, 1'b0);
                    else if (c.next_owner != O_NONE && !owner_valid(c.next_owner))
                        st = note_failure(ST_INVALID, 1'b0);
                    else
                    begin
                        slot_state[s] = S_DELIVERED;
                        slot_owner[s] = c.next_owner;
                    end
                end
                else
                begin
                    if (slot_state[s] < S_ALLOCATED || slot_state[s] > S_IN_FLIGHT)
                        st = note_failure(ST_STATE, 1'b0);
                    else if (c.next_owner != O_NONE)
                        st = note_failure(ST_INVALID, 1'b0);
                    else
                    begin
                        slot_state[s] = S_DROPPED;
                        slot_owner[s] = O_NONE;
                        slot_err[s]   = c.completion_code;
                    end
                end
            end
            CMD_RETAIN:
            begin
                st = liveness(s);
                if (st == ST_OK && slot_refs[s] == REF_MAX)
                    st = ST_OVERFLOW;
                if (st != ST_OK)
                    void'(note_failure(st, 1'b0));
                else
                    slot_refs[s] = slot_refs[s] + 16'd1;
            end
            CMD_RELEASE:
            begin
                st = liveness(s);
                if (st == ST_OK && slot_state[s] != S_DELIVERED &&
                    slot_state[s] != S_DROPPED)
                begin
                    st = ST_STATE;
                end
                if (st != ST_OK)
                    void'(note_failure(st, 1'b0));
                else if (slot_refs[s] > 16'd1)
                    slot_refs[s] = slot_refs[s] - 16'd1;
                else
                begin
                    slot_refs[s]  = '0;
                    slot_state[s] = S_FREED;
                    slot_owner[s] = O_NONE;
                    slot_busy[s]  = 1'b0;
                    if (live_count != '0)
                        live_count = live_count - 6'd1;
                end
            end
            default:
            begin
                st = ST_INVALID;
            end
        endcase
        r          = '0;
        r.status   = st;
        r.granted  = granted;
        if (show)
        begin
            r.state    = slot_state[s];
            r.owner    = slot_owner[s];
            r.refs     = slot_refs[s];
            r.tailroom = slot_busy[s] ? slot_tail[s] : 16'd0;
        end
        r.active   = live_count;
        r.peak     = peak_seen;
        r.fails    = fails_seen;
        r.dups     = dups_seen;
        r.last_err = last_fault;
        return r;
    endfunction

    function automatic void check_field(string field, longint unsigned want,
                                        longint unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, actual %0d", field, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        table_result_t want;
        if (!rst_n)
        begin
            clear_table();
            pending_results.delete();
        end
        else
        begin
            if (in_valid && !in_stall)
                pending_results.push_back(run_command({cmd, slot, capacity, headroom,
                    payload_length, alignment, next_state, next_owner, completion_code}));
            if (out_valid && !out_stall)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("result beat arrived with no command outstanding");
                    mismatches++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    check_field("status", want.status, status);
                    check_field("granted_slot", want.granted, granted_slot);
                    check_field("entry_state", want.state, entry_state);
                    check_field("entry_owner", want.owner, entry_owner);
                    check_field("entry_refs", want.refs, entry_refs);
                    check_field("entry_tailroom", want.tailroom, entry_tailroom);
                    check_field("active_count", want.active, active_count);
                    check_field("peak_count", want.peak, peak_count);
                    check_field("failure_count", want.fails, failure_count);
                    check_field("duplicate_count", want.dups, duplicate_count);
                    check_field("last_error_code", want.last_err, last_error_code);
                end
            end
        end
        backlog <= pending_results.size();
    end

endmodule

@@ tb/packet_buffer_lifecycle_table_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Packet buffer lifecycle table: testbench top
// Drives descriptor commands into the table and stalls its result channel at
// random. A directed walk through every command and a set of refusals comes
// first, then a burst that fills the table behind a long receiver hold-off, a
// reference count run up to saturation, and finally random lifecycle traffic.
// The checker beside the block predicts and compares every result beat.
// ----------------------------------------------------------------------------
module packet_buffer_lifecycle_table_tb;
    import pblt_pkg::*;

    // Codes outside the defined sets, used to probe the refusal paths.
    localparam logic [2:0] CMD_UNDEFINED   = 3'd7;
    localparam logic [2:0] OWNER_UNDEFINED = 3'd7;

    localparam int HOLD_CYCLES  = 120;
    localparam int RANDOM_BEATS = 500;
    localparam int IDLE_PCT     = 21;

    logic        clk;
    logic        rst_n           = 1'b0;
    logic        in_valid        = 1'b0;
    logic        in_stall;
    logic [2:0]  cmd             = '0;
    logic [4:0]  slot            = '0;
    logic [15:0] capacity        = '0;
    logic [15:0] headroom        = '0;
    logic [15:0] payload_length  = '0;
    logic [12:0] alignment       = '0;
    logic [2:0]  next_state      = '0;
    logic [2:0]  next_owner      = '0;
    logic [7:0]  completion_code = '0;
    logic        out_valid;
    logic        out_stall       = 1'b0;
    logic [1:0]  status;
    logic [4:0]  granted_slot;
    logic [2:0]  entry_state;
    logic [2:0]  entry_owner;
    logic [15:0] entry_refs;
    logic [15:0] entry_tailroom;
    logic [5:0]  active_count;
    logic [5:0]  peak_count;
    logic [31:0] failure_count;
    logic [31:0] duplicate_count;
    logic [1:0]  last_error_code;

    int unsigned mismatches;
    int unsigned backlog;

    // Set while both sides must run without gaps.
    bit steady   = 1'b0;
    // Raised by the stimulus to ask the receiver for one long hold-off.
    bit hold_req = 1'b0;

    packet_buffer_lifecycle_table uut (.*);

    packet_buffer_lifecycle_table_checker table_check (.*);

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Watchdog: the slowest legal run is well under a tenth of this.
    initial
    begin
        #2_000_000;
        $display("packet_buffer_lifecycle_table: mismatch");
        $finish;
    end

    // Result side. Stalls at random, except during the steady stretch. On a
    // hold request it keeps the stall high through one long hold-off so that
    // the block backs up and raises in_stall against the sender.
    initial
    begin : receiver
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            out_stall <= !steady && ($urandom_range(99) < IDLE_PCT);
        end
    end

    // Offers one command beat and returns just after the edge that took it.
    // The stall is sampled on the falling edge, where it has settled, and the
    // payload is held untouched until the beat is taken.
    task automatic send_beat(input logic [2:0] op, input logic [4:0] sl,
                             input logic [15:0] cap, input logic [15:0] hr,
                             input logic [15:0] len, input logic [12:0] al,
                             input logic [2:0] ns, input logic [2:0] no,
                             input logic [7:0] code);
        bit taken;
        while (!steady && $urandom_range(99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid        <= 1'b1;
        cmd             <= op;
        slot            <= sl;
        capacity        <= cap;
        headroom        <= hr;
        payload_length  <= len;
        alignment       <= al;
        next_state      <= ns;
        next_owner      <= no;
        completion_code <= code;
        do
        begin
            @(negedge clk);
            taken = !in_stall;
            @(posedge clk);
        end
        while (!taken);
    endtask

    // Random lifecycle traffic. Most beats are well-formed commands aimed at
    // the low slots, where allocations land, so buffers actually travel from
    // allocate through transitions and completion to release. About one beat
    // in ten is pure noise with every field random, which also covers the
    // undefined command and every bit of every field.
    task automatic send_random_beat();
        logic [2:0]  op;
        logic [4:0]  sl;
        logic [15:0] cap;
        logic [15:0] hr;
        logic [15:0] len;
        logic [12:0] al;
        logic [2:0]  ns;
        logic [2:0]  no;
        logic [7:0]  code;
        int unsigned pick;
        pick = $urandom_range(99);
        sl   = ($urandom_range(99) < 80) ? 5'($urandom_range(15)) : 5'($urandom);
        cap  = 16'($urandom_range(64, 2048));
        hr   = 16'($urandom_range(32));
        len  = 16'($urandom_range(512));
        al   = 13'(1 << $urandom_range(12));
        ns   = 3'($urandom_range(S_RX, S_IN_FLIGHT));
        no   = 3'($urandom_range(O_DRIVER, O_SOCKET));
        code = '0;
        if (pick < 10)
        begin
            op   = 3'($urandom);
            sl   = 5'($urandom);
            cap  = 16'($urandom);
            hr   = 16'($urandom);
            len  = 16'($urandom);
            al   = 13'($urandom);
            ns   = 3'($urandom);
            no   = 3'($urandom);
            code = 8'($urandom);
        end
        else if (pick < 25)
            op = CMD_ALLOCATE;
        else if (pick < 33)
            op = CMD_SET_LAYOUT;
        else if (pick < 40)
            op = CMD_SET_LENGTH;
        else if (pick < 60)
        begin
            op = CMD_TRANSITION;
            // Mostly pick an owner that suits the target state.
            if ($urandom_range(99) < 70)
            begin
                if (ns == S_RX)
                    no = 3'($urandom_range(O_DRIVER, O_ETHERNET));
                else if (ns == S_QUEUED)
                    no = 3'($urandom_range(O_PROTOCOL, O_SOCKET));
            end
        end
        else if (pick < 78)
        begin
            op = CMD_COMPLETE;
            if ($urandom_range(1))
                no = 3'($urandom_range(O_NONE, O_SOCKET));
            else
            begin
                code = 8'($urandom_range(1, 255));
                no   = ($urandom_range(99) < 85) ? O_NONE : 3'($urandom);
            end
        end
        else if (pick < 84)
            op = CMD_RETAIN;
        else
            op = CMD_RELEASE;
        send_beat(op, sl, cap, hr, len, al, ns, no, code);
    endtask

    initial
    begin : stimulus
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed walk. Allocate refusals first: zero capacity, headroom past
        // capacity, zero alignment, alignment that is neither a power of two
        // nor within the maximum, and owners outside the legal range.
        send_beat(CMD_ALLOCATE, 5'd0, 16'd0, 16'd0, 16'd0, 13'd64,
                  S_INVALID, O_DRIVER, 8'd0);
        send_beat(CMD_ALLOCATE, 5'd0, 16'd100, 16'd101, 16'd0, 13'd64,
                  S_INVALID, O_DRIVER, 8'd0);
        send_beat(CMD_ALLOCATE, 5'd0, 16'd100, 16'd0, 16'd0, 13'd0,
                  S_INVALID, O_DRIVER, 8'd0);
        send_beat(CMD_ALLOCATE, 5'd0, 16'd100, 16'd0, 16'd0, 13'h1FFF,
                  S_INVALID, O_DRIVER, 8'd0);
        send_beat(CMD_ALLOCATE, 5'd0, 16'd100, 16'd0, 16'd0, 13'd64,
                  S_INVALID, O_NONE, 8'd0);
        send_beat(CMD_ALLOCATE, 5'd0, 16'd100, 16'd0, 16'd0, 13'd64,
                  S_INVALID, OWNER_UNDEFINED, 8'd0);
        // Largest buffer at the largest alignment lands in slot 0; a one-byte
        // buffer that is all headroom lands in slot 1 with no tailroom.
        send_beat(CMD_ALLOCATE, 5'd0, 16'hFFFF, 16'd0, 16'd0, MAX_ALIGN,
                  S_INVALID, O_SOCKET, 8'd0);
        send_beat(CMD_ALLOCATE, 5'd31, 16'd1, 16'd1, 16'd0, 13'd1,
                  S_INVALID, O_DRIVER, 8'd0);
        // Layout that fills the buffer exactly, then a length one byte over.
        send_beat(CMD_SET_LAYOUT, 5'd0, 16'd0, 16'd16, 16'd65519, 13'd0,
                  S_INVALID, O_NONE, 8'd0);
        send_beat(CMD_SET_LENGTH, 5'd0, 16'd0, 16'd0, 16'd65520, 13'd0,
                  S_INVALID, O_NONE, 8'd0);
        // Unregistered slot at the top of the handle range.
        send_beat(CMD_SET_LAYOUT, 5'd31, 16'd0, 16'hFFFF, 16'hFFFF, 13'd0,
                  S_INVALID, O_NONE, 8'd0);
        // Transitions: illegal target, bad owner for the target, a legal move,
        // then a move that the current state forbids.
        send_beat(CMD_TRANSITION, 5'd0, 16'd0, 16'd0, 16'd0, 13'd0,
                  S_DELIVERED, O_DRIVER, 8'd0);
        send_beat(CMD_TRANSITION, 5'd0, 16'd0, 16'd0, 16'd0, 13'd0,
                  S_RX, O_PROTOCOL, 8'd0);
        send_beat(CMD_TRANSITION, 5'd0, 16'd0, 16'd0, 16'd0, 13'd0,
                  S_RX, O_ETHERNET, 8'd0);
        send_beat(CMD_TRANSITION, 5'd0, 16'd0, 16'd0, 16'd0, 13'd0,
                  S_RX, O_DRIVER, 8'd0);
        // Completions: deliver from the allocated state is refused, an
        // undefined owner is refused, a good delivery, then a duplicate.
        send_beat(CMD_COMPLETE, 5'd1, 16'd0, 16'd0, 16'd0, 13'd0,
                  S_INVALID, O_NONE, 8'd0);
        send_beat(CMD_COMPLETE, 5'd0, 16'd0, 16'd0, 16'd0, 13'd0,
                  S_INVALID, OWNER_UNDEFINED, 8'd0);
        send_beat(CMD_COMPLETE, 5'd0, 16'd0, 16'd0, 16'd0, 13'd0,
                  S_INVALID, O_SOCKET, 8'd0);
        send_beat(CMD_COMPLETE, 5'd0, 16'd0, 16'd0, 16'd0, 13'd0,
                  S_INVALID, O_NONE, 8'hFF);
        // Reference counting down to the last release, then one release too
        // many and a release of a buffer that is not yet completed.
        send_beat(CMD_RETAIN, 5'd0, 16'd0, 16'd0, 16'd0, 13'd0,
                  S_INVALID, O_NONE, 8'd0);
        repeat (3)
            send_beat(CMD_RELEASE, 5'd0, 16'd0, 16'd0, 16'd0, 13'd0,
                      S_INVALID, O_NONE, 8'd0);
        send_beat(CMD_RELEASE, 5'd1, 16'd0, 16'd0, 16'd0, 13'd0,
                  S_INVALID, O_NONE, 8'd0);
        // A drop must not name an owner; then a clean drop with an error code.
        send_beat(CMD_COMPLETE, 5'd1, 16'd0, 16'd0, 16'd0, 13'd0,
                  S_INVALID, O_DRIVER, 8'h80);
        send_beat(CMD_COMPLETE, 5'd1, 16'd0, 16'd0, 16'd0, 13'd0,
                  S_INVALID, O_NONE, 8'h80);
        send_beat(CMD_UNDEFINED, 5'd1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 13'h1FFF,
                  S_FREED, OWNER_UNDEFINED, 8'hFF);
        send_beat(CMD_RELEASE, 5'd1, 16'd0, 16'd0, 16'd0, 13'd0,
                  S_INVALID, O_NONE, 8'd0);

        // Fill the whole table while the receiver holds off, so the block
        // backs up and stalls the sender; the last two allocates find no
        // free slot. Then drop and release every slot to empty it again.
        hold_req = 1'b1;
        repeat (SLOTS + 2)
            send_beat(CMD_ALLOCATE, 5'($urandom), 16'($urandom_range(64, 1500)),
                      16'($urandom_range(64)), 16'd0, 13'(1 << $urandom_range(12)),
                      S_INVALID, 3'($urandom_range(O_DRIVER, O_SOCKET)), 8'd0);
        for (int k = 0; k < SLOTS; k++)
        begin
            send_beat(CMD_COMPLETE, 5'(k), 16'd0, 16'd0, 16'd0, 13'd0,
                      S_INVALID, O_NONE, 8'($urandom_range(1, 255)));
            send_beat(CMD_RELEASE, 5'(k), 16'd0, 16'd0, 16'd0, 13'd0,
                      S_INVALID, O_NONE, 8'd0);
        end
        in_valid <= 1'b0;

        // Let the block drain completely before going on.
        do
            @(negedge clk);
        while (backlog != 0);
        @(posedge clk);

        // Run the reference count of slot 0 up to its ceiling and once past
        // it, back to back on both sides.
        steady = 1'b1;
        send_beat(CMD_ALLOCATE, 5'd0, 16'd256, 16'd0, 16'd0, 13'd1,
                  S_INVALID, O_DRIVER, 8'd0);
        repeat (int'(REF_MAX))
            send_beat(CMD_RETAIN, 5'd0, 16'd0, 16'd0, 16'd0, 13'd0,
                      S_INVALID, O_NONE, 8'd0);
        steady = 1'b0;

        repeat (RANDOM_BEATS)
            send_random_beat();
        in_valid <= 1'b0;

        do
            @(negedge clk);
        while (backlog != 0);
        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("packet_buffer_lifecycle_table: match");
        else
            $display("packet_buffer_lifecycle_table: mismatch");
        $finish;
    end

endmodule

@@ sim.f @@
design/pblt_pkg.sv
design/pblt_desc_mem.sv
design/pblt_cmd_unit.sv
design/packet_buffer_lifecycle_table.sv
tb/packet_buffer_lifecycle_table_checker.sv
tb/packet_buffer_lifecycle_table_tb.sv
